[sv/oml_pkg.sv]
// Shared types and codes for the ordered mark list.
// No dependencies; imported by oml_cell and ordered_mark_list_unit.
`timescale 1ns / 1ps

package oml_pkg;

  // request codes
  localparam logic [1:0] REQ_MARK   = 2'd0;
  localparam logic [1:0] REQ_UNMARK = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_JOINED     = 3'd0;
  localparam logic [2:0] ST_ALREADY    = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_LISTED = 3'd3;
  localparam logic [2:0] ST_OTHER_KIND = 3'd4;
  localparam logic [2:0] ST_FULL_DROP  = 3'd5;
  localparam logic [2:0] ST_ENTRY      = 3'd6;
  localparam logic [2:0] ST_EMPTY      = 3'd7;

  // a dump reports at most this many entries
  localparam int MAX_RESULTS = 16;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic append;  // write the request index into the cell at the tail
    logic remove;  // cells at and above the match take their neighbour's entry
    logic rotate;  // one step of the dump rotation
  } cell_cmd_t;

endpackage

[sv/oml_cell.sv]
// One cell of the list chain: holds one entry, compares it with the request
// index and passes the match prefix on.  Depends on oml_pkg.
`timescale 1ns / 1ps

module oml_cell import oml_pkg::*; #(
  parameter int POS = 0,
  parameter int IW  = 8,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [CW-1:0] count,
  input  logic [IW-1:0] idx,
  input  logic [IW-1:0] nbr_entry,   // entry of the next younger cell
  input  logic [IW-1:0] wrap_entry,  // entry of cell zero, for rotation
  input  logic          shift_in,
  output logic          shift_out,
  output logic [IW-1:0] entry
);

  logic [IW-1:0] entry_r, entry_nxt;
  logic          valid, match;

  assign valid     = count > CW'(POS);
  assign match     = valid && (entry_r == idx);
  // set from the matching cell upwards
  assign shift_out = shift_in | match;
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.append && count == CW'(POS)) begin
      entry_nxt = idx;
    end else if (cmd.remove && shift_out) begin
      entry_nxt = nbr_entry;
    end else if (cmd.rotate) begin
      entry_nxt = (count == CW'(POS + 1)) ? wrap_entry : nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[sv/ordered_mark_list_unit.sv]
// Top level of the ordered mark list: request decode, count, dump sequencer
// and output register.  Depends on oml_pkg and oml_cell.
`timescale 1ns / 1ps

// Keeps an insertion-ordered list of up to LIST_DEPTH cell indices for the
// mark kind held in the configuration register. The list lives in a chain of
// cells; every cell compares its entry with the request index at once, so a
// mark, unmark or clear request is resolved at its accept edge, and in_ready
// is high again as soon as the single result can be placed in the output
// register. A dump rotates the chain by one entry per cycle, pausing while an
// entry to be reported finds the output slot full, and emits cell zero each
// time, so it holds the input until its rotation is through; only the oldest
// 16 entries are reported, the rest of the rotation runs silently. A dump of
// an empty list is resolved at its accept edge like a clear, its single
// result registered there. Requests are taken only between dumps.

module ordered_mark_list_unit import oml_pkg::*; #(
  parameter int LIST_DEPTH  = 16,
  parameter int INDEX_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_cell_index,
  input  logic [3:0] in_mark_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_entry_index,
  output logic [3:0] out_position,
  output logic [4:0] out_list_count,
  output logic       out_is_last
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = INDEX_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    watched_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] step_r, step_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    entry_r, entry_nxt;
  logic [3:0]    pos_r, pos_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          last_r, last_nxt;

  cell_cmd_t     cmd;
  logic [IW-1:0] idx;
  logic [IW-1:0] entry_w [LIST_DEPTH];
  logic          shift_w [LIST_DEPTH+1];

  logic accept, slot_free, kind_ok, found, full;
  logic emit, dump_go, dump_done;

  assign idx       = IW'(in_cell_index);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign kind_ok   = in_mark_kind == watched_r;
  assign found     = shift_w[LIST_DEPTH];
  assign full      = count_r == CW'(LIST_DEPTH);

  // dump sequencing: steps past the report limit need no output slot
  assign emit      = 32'(step_r) < 32'(MAX_RESULTS);
  assign dump_go   = (state_r == S_DUMP) && (!emit || slot_free);
  assign dump_done = step_r == count_r - 1'b1;

  always_comb begin
    cmd.append = accept && in_req_type == REQ_MARK && kind_ok && !found && !full;
    cmd.remove = accept && in_req_type == REQ_UNMARK && kind_ok && found;
    cmd.rotate = dump_go;
  end

  assign shift_w[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [IW-1:0] nbr;
    if (i < LIST_DEPTH - 1) begin : g_mid
      assign nbr = entry_w[i+1];
    end else begin : g_end
      assign nbr = entry_w[0];
    end

    oml_cell #(
      .POS(i),
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .idx       (idx),
      .nbr_entry (nbr),
      .wrap_entry(entry_w[0]),
      .shift_in  (shift_w[i]),
      .shift_out (shift_w[i+1]),
      .entry     (entry_w[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;

    if (cmd.append) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.remove) begin
      count_nxt = count_r - 1'b1;
    end

    if (accept) begin
      entry_nxt = '0;
      pos_nxt   = '0;
      last_nxt  = 1'b1;
      unique case (in_req_type) inside
        REQ_MARK, REQ_UNMARK: begin
          out_valid_nxt = 1'b1;
          if (!kind_ok) begin
            status_nxt = ST_OTHER_KIND;
          end else if (in_req_type == REQ_MARK) begin
            status_nxt = found ? ST_ALREADY : (full ? ST_FULL_DROP : ST_JOINED);
          end else begin
            status_nxt = found ? ST_REMOVED : ST_NOT_LISTED;
          end
          cnt_nxt = 5'(count_nxt);
        end
        REQ_CLEAR: begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_EMPTY;
          cnt_nxt       = '0;
          count_nxt     = '0;
        end
        default: begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_EMPTY;
            cnt_nxt       = '0;
          end else begin
            state_nxt = S_DUMP;
            step_nxt  = '0;
          end
        end
      endcase
    end

    if (dump_go) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_ENTRY;
        entry_nxt     = 8'(entry_w[0]);
        pos_nxt       = 4'(step_r);
        cnt_nxt       = 5'(count_r);
        last_nxt      = dump_done || 32'(step_r) == 32'(MAX_RESULTS - 1);
      end
      step_nxt = step_r + 1'b1;
      if (dump_done) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      watched_r   <= '0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        watched_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    pos_r    <= pos_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_index = entry_r;
  assign out_position    = pos_r;
  assign out_list_count  = cnt_r;
  assign out_is_last     = last_r;

endmodule
